// ----- hdl/gbt_pkg.sv -----
package gbt_pkg;

  localparam int VTX_W       = 4;
  localparam int CFG_W       = 5;
  localparam int OP_W        = 2;
  localparam int ST_W        = 2;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 8;

  localparam logic [OP_W-1:0] OP_EDGE = 2'd0;
  localparam logic [OP_W-1:0] OP_BFS  = 2'd1;
  localparam logic [OP_W-1:0] OP_DFS  = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  localparam logic [CFG_W-1:0] VERTEX_COUNT_RST = 5'd16;

endpackage

// ----- hdl/gbt_ram.sv -----
module gbt_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/graph_bfs_dfs_traversal.sv -----
// Undirected graph store with breadth-first and depth-first search. An input beat carries an
// opcode in in_tuser (add edge, BFS, DFS) and two vertices in in_tdata. Each beat gives one
// result beat (edge status or range error), or one beat per reachable vertex in visiting order,
// with out_tlast on the final one; an unused opcode is dropped without a result. Neighbor lists,
// degrees and the queue/stack live in single-read-port RAMs with a registered read, so
// the rate is set by the neighbor-list read port. A traversal pops each entry, reads the
// vertex's degree and then reads its stored neighbor entries one after another; a DFS entry
// whose vertex was already visited is popped and skipped. Back-pressure on out_tready can
// hold a traversal or a result until the output register frees. Input is taken only between
// items; the output register lets a result wait while the next item is accepted.
module graph_bfs_dfs_traversal #(
  parameter int MAX_VERTICES = 16,
  parameter int MAX_DEGREE   = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [gbt_pkg::IN_TDATA_W-1:0]   in_tdata,   // first_vertex, second_vertex
  input  logic [gbt_pkg::OP_W-1:0]         in_tuser,   // opcode
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [gbt_pkg::OUT_TDATA_W-1:0]  out_tdata,  // visited_vertex
  output logic                             out_tlast,
  output logic [gbt_pkg::ST_W-1:0]         out_tuser,  // status
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gbt_pkg::CFG_W-1:0]        cfg_data
);

  import gbt_pkg::*;

  localparam int VIW       = $clog2(MAX_VERTICES);
  localparam int DW        = $clog2(MAX_DEGREE + 1);
  localparam int NBR_DEPTH = MAX_VERTICES * MAX_DEGREE;
  localparam int NAW       = $clog2(NBR_DEPTH);
  localparam int WL_DEPTH  = NBR_DEPTH + 1;
  localparam int WAW       = $clog2(WL_DEPTH);
  localparam int PW        = $clog2(WL_DEPTH + 1);
  localparam int CW0       = $clog2(MAX_VERTICES + 1);
  localparam int CW        = (CW0 > CFG_W) ? CW0 : CFG_W;

  typedef enum logic [3:0] {
    S_IDLE, S_E_RDU, S_E_RDV, S_E_WRV, S_RESULT, S_POP, S_NODE, S_DEG, S_SCAN, S_FLUSH
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CFG_W-1:0]        vc_r, vc_nxt;
  logic [CW-1:0]           n_r, n_nxt;
  logic                    dfs_r, dfs_nxt;
  logic [VTX_W-1:0]        u_r, u_nxt;
  logic [VTX_W-1:0]        v_r, v_nxt;
  logic [DW-1:0]           du_r, du_nxt;
  logic [DW-1:0]           dv_r, dv_nxt;
  logic [ST_W-1:0]         status_r, status_nxt;
  logic [PW-1:0]           head_r, head_nxt;
  logic [PW-1:0]           tail_r, tail_nxt;
  logic [VTX_W-1:0]        node_r, node_nxt;
  logic [DW-1:0]           deg_r, deg_nxt;
  logic [DW-1:0]           slot_r, slot_nxt;
  logic                    rd_pend_r, rd_pend_nxt;
  logic [MAX_VERTICES-1:0] vis_r, vis_nxt;
  logic [MAX_VERTICES-1:0] deg_vld_r, deg_vld_nxt;
  logic [VIW-1:0]          deg_raddr_r, deg_raddr_nxt;
  logic                    pend_vld_r, pend_vld_nxt;
  logic [VTX_W-1:0]        pend_vtx_r, pend_vtx_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [VTX_W-1:0]        out_vtx_r, out_vtx_nxt;
  logic                    out_last_r, out_last_nxt;
  logic [ST_W-1:0]         out_status_r, out_status_nxt;

  logic                    nbr_we, nbr_re;
  logic [NAW-1:0]          nbr_waddr, nbr_raddr;
  logic [VTX_W-1:0]        nbr_wdata, nbr_q;
  logic                    deg_we, deg_re;
  logic [VIW-1:0]          deg_waddr;
  logic [DW-1:0]           deg_wdata, deg_q, deg_eff;
  logic                    wl_we, wl_re;
  logic [WAW-1:0]          wl_waddr, wl_raddr;
  logic [VTX_W-1:0]        wl_wdata, wl_q;

  logic [CW-1:0]           n_now;
  logic                    slot_free;
  logic [VTX_W-1:0]        in_u, in_v;
  logic [VIW-1:0]          node_idx, nb_idx, wl_idx;
  logic                    du_full, dv_full, self_full;

  gbt_ram #(.WIDTH(VTX_W), .DEPTH(NBR_DEPTH)) u_nbr_ram (
    .clk     (clk),
    .wr_en   (nbr_we),
    .wr_addr (nbr_waddr),
    .wr_data (nbr_wdata),
    .rd_en   (nbr_re),
    .rd_addr (nbr_raddr),
    .rd_data (nbr_q)
  );

  gbt_ram #(.WIDTH(DW), .DEPTH(MAX_VERTICES)) u_deg_ram (
    .clk     (clk),
    .wr_en   (deg_we),
    .wr_addr (deg_waddr),
    .wr_data (deg_wdata),
    .rd_en   (deg_re),
    .rd_addr (deg_raddr_nxt),
    .rd_data (deg_q)
  );

  gbt_ram #(.WIDTH(VTX_W), .DEPTH(WL_DEPTH)) u_wl_ram (
    .clk     (clk),
    .wr_en   (wl_we),
    .wr_addr (wl_waddr),
    .wr_data (wl_wdata),
    .rd_en   (wl_re),
    .rd_addr (wl_raddr),
    .rd_data (wl_q)
  );

  assign in_u      = in_tdata[VTX_W-1:0];
  assign in_v      = in_tdata[2*VTX_W-1:VTX_W];
  assign slot_free = !out_valid_r || out_tready;
  assign deg_eff   = deg_vld_r[deg_raddr_r] ? deg_q : '0;
  assign node_idx  = VIW'(node_r);
  assign nb_idx    = VIW'(nbr_q);
  assign wl_idx    = VIW'(wl_q);
  assign du_full   = du_r >= DW'(MAX_DEGREE);
  assign dv_full   = deg_eff >= DW'(MAX_DEGREE);
  assign self_full = ((DW+1)'(du_r) + (DW+1)'(2)) > (DW+1)'(MAX_DEGREE);

  always_comb begin
    if (vc_r == '0) begin
      n_now = CW'(1);
    end else if (CW'(vc_r) > CW'(MAX_VERTICES)) begin
      n_now = CW'(MAX_VERTICES);
    end else begin
      n_now = CW'(vc_r);
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_vtx_r);
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    vc_nxt         = vc_r;
    n_nxt          = n_r;
    dfs_nxt        = dfs_r;
    u_nxt          = u_r;
    v_nxt          = v_r;
    du_nxt         = du_r;
    dv_nxt         = dv_r;
    status_nxt     = status_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    node_nxt       = node_r;
    deg_nxt        = deg_r;
    slot_nxt       = slot_r;
    rd_pend_nxt    = rd_pend_r;
    vis_nxt        = vis_r;
    deg_vld_nxt    = deg_vld_r;
    deg_raddr_nxt  = deg_raddr_r;
    pend_vld_nxt   = pend_vld_r;
    pend_vtx_nxt   = pend_vtx_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_vtx_nxt    = out_vtx_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;

    nbr_we    = 1'b0;
    nbr_waddr = '0;
    nbr_wdata = '0;
    nbr_re    = 1'b0;
    nbr_raddr = '0;
    deg_we    = 1'b0;
    deg_waddr = '0;
    deg_wdata = '0;
    deg_re    = 1'b0;
    wl_we     = 1'b0;
    wl_waddr  = '0;
    wl_wdata  = '0;
    wl_re     = 1'b0;
    wl_raddr  = '0;

    if (cfg_valid) begin
      vc_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          u_nxt = in_u;
          v_nxt = in_v;
          n_nxt = n_now;
          unique case (in_tuser)
            OP_EDGE: begin
              if (CW'(in_u) >= n_now || CW'(in_v) >= n_now) begin
                status_nxt = ST_RANGE;
                state_nxt  = S_RESULT;
              end else begin
                deg_re        = 1'b1;
                deg_raddr_nxt = VIW'(in_u);
                state_nxt     = S_E_RDU;
              end
            end
            OP_BFS, OP_DFS: begin
              if (CW'(in_u) >= n_now) begin
                status_nxt = ST_RANGE;
                state_nxt  = S_RESULT;
              end else begin
                dfs_nxt = (in_tuser == OP_DFS);
                vis_nxt = '0;
                if (in_tuser == OP_BFS) begin
                  vis_nxt[VIW'(in_u)] = 1'b1;
                end
                wl_we        = 1'b1;
                wl_waddr     = '0;
                wl_wdata     = in_u;
                head_nxt     = '0;
                tail_nxt     = PW'(1);
                pend_vld_nxt = 1'b0;
                state_nxt    = S_POP;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_E_RDU: begin
        du_nxt        = deg_eff;
        deg_re        = 1'b1;
        deg_raddr_nxt = VIW'(v_r);
        state_nxt     = S_E_RDV;
      end

      S_E_RDV: begin
        if ((u_r == v_r) ? self_full : (du_full || dv_full)) begin
          status_nxt = ST_FULL;
          state_nxt  = S_RESULT;
        end else begin
          nbr_we    = 1'b1;
          nbr_waddr = NAW'(NAW'(VIW'(u_r)) * NAW'(MAX_DEGREE) + NAW'(du_r));
          nbr_wdata = v_r;
          deg_we    = 1'b1;
          deg_waddr = VIW'(u_r);
          deg_wdata = du_r + DW'(1);
          deg_vld_nxt[VIW'(u_r)] = 1'b1;
          dv_nxt    = (u_r == v_r) ? (du_r + DW'(1)) : deg_eff;
          state_nxt = S_E_WRV;
        end
      end

      S_E_WRV: begin
        nbr_we    = 1'b1;
        nbr_waddr = NAW'(NAW'(VIW'(v_r)) * NAW'(MAX_DEGREE) + NAW'(dv_r));
        nbr_wdata = u_r;
        deg_we    = 1'b1;
        deg_waddr = VIW'(v_r);
        deg_wdata = dv_r + DW'(1);
        deg_vld_nxt[VIW'(v_r)] = 1'b1;
        status_nxt = ST_OK;
        state_nxt  = S_RESULT;
      end

      S_RESULT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_vtx_nxt    = '0;
          out_last_nxt   = 1'b1;
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end

      S_POP: begin
        if (tail_r > head_r) begin
          wl_re = 1'b1;
          if (dfs_r) begin
            wl_raddr = WAW'(tail_r - PW'(1));
            tail_nxt = tail_r - PW'(1);
          end else begin
            wl_raddr = WAW'(head_r);
            head_nxt = head_r + PW'(1);
          end
          state_nxt = S_NODE;
        end else begin
          state_nxt = S_FLUSH;
        end
      end

      S_NODE: begin
        if (dfs_r && vis_r[wl_idx]) begin
          state_nxt = S_POP;
        end else if (!pend_vld_r || slot_free) begin
          if (pend_vld_r) begin
            out_valid_nxt  = 1'b1;
            out_vtx_nxt    = pend_vtx_r;
            out_last_nxt   = 1'b0;
            out_status_nxt = ST_OK;
          end
          pend_vld_nxt = 1'b1;
          pend_vtx_nxt = wl_q;
          if (dfs_r) begin
            vis_nxt[wl_idx] = 1'b1;
          end
          node_nxt      = wl_q;
          deg_re        = 1'b1;
          deg_raddr_nxt = wl_idx;
          state_nxt     = S_DEG;
        end
      end

      S_DEG: begin
        deg_nxt     = deg_eff;
        slot_nxt    = '0;
        rd_pend_nxt = 1'b0;
        state_nxt   = S_SCAN;
      end

      S_SCAN: begin
        if (rd_pend_r && CW'(nbr_q) < n_r && !vis_r[nb_idx] &&
            tail_r < PW'(WL_DEPTH)) begin
          wl_we    = 1'b1;
          wl_waddr = WAW'(tail_r);
          wl_wdata = nbr_q;
          tail_nxt = tail_r + PW'(1);
          if (!dfs_r) begin
            vis_nxt[nb_idx] = 1'b1;
          end
        end
        if (slot_r < deg_r) begin
          nbr_re      = 1'b1;
          nbr_raddr   = NAW'(NAW'(node_idx) * NAW'(MAX_DEGREE) + NAW'(slot_r));
          slot_nxt    = slot_r + DW'(1);
          rd_pend_nxt = 1'b1;
        end else begin
          rd_pend_nxt = 1'b0;
          state_nxt   = S_POP;
        end
      end

      S_FLUSH: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_vtx_nxt    = pend_vtx_r;
          out_last_nxt   = 1'b1;
          out_status_nxt = ST_OK;
          pend_vld_nxt   = 1'b0;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vc_r        <= VERTEX_COUNT_RST;
      rd_pend_r   <= 1'b0;
      vis_r       <= '0;
      deg_vld_r   <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      vc_r        <= vc_nxt;
      rd_pend_r   <= rd_pend_nxt;
      vis_r       <= vis_nxt;
      deg_vld_r   <= deg_vld_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
    end
    n_r          <= n_nxt;
    dfs_r        <= dfs_nxt;
    u_r          <= u_nxt;
    v_r          <= v_nxt;
    du_r         <= du_nxt;
    dv_r         <= dv_nxt;
    status_r     <= status_nxt;
    node_r       <= node_nxt;
    deg_r        <= deg_nxt;
    slot_r       <= slot_nxt;
    deg_raddr_r  <= deg_raddr_nxt;
    pend_vtx_r   <= pend_vtx_nxt;
    out_vtx_r    <= out_vtx_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

// ----- sim/graph_bfs_dfs_traversal_tb.sv -----
`timescale 1ns / 100ps

module graph_bfs_dfs_traversal_tb;
  import gbt_pkg::*;

  localparam int NUM_VTX        = 16;
  localparam int NUM_DEG        = 8;
  localparam int WORK_SLOTS     = NUM_VTX * NUM_DEG + 1;
  localparam int DRAIN_CYCLES   = 250;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int IDLE_PCT       = 6;
  localparam int PHASE_ITEMS    = 40;
  localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} check_mode_t;

  typedef struct packed {
    logic [VTX_W-1:0] vertex;
    logic             last;
    logic [ST_W-1:0]  status;
  } visit_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [OP_W-1:0]  op;
    logic [CFG_W-1:0] arg_a;
    logic [VTX_W-1:0] arg_b;
    check_mode_t      mode;
    visit_t           typed;
  } stim_row_t;

  localparam visit_t NO_VISIT = '0;

  localparam stim_row_t DIRECTED [27] = '{
    '{ROW_ITEM, OP_BFS,     5'd0,  4'd0,  CHK_ONE,   '{4'd0,  1'b1, ST_OK}},
    '{ROW_ITEM, OP_DFS,     5'd15, 4'd0,  CHK_ONE,   '{4'd15, 1'b1, ST_OK}},
    '{ROW_ITEM, OP_EDGE,    5'd0,  4'd15, CHK_ONE,   '{4'd0,  1'b1, ST_OK}},
    '{ROW_ITEM, OP_EDGE,    5'd15, 4'd15, CHK_ONE,   '{4'd0,  1'b1, ST_OK}},
    '{ROW_ITEM, OP_IGNORED, 5'd5,  4'd9,  CHK_NONE,  NO_VISIT},
    '{ROW_ITEM, OP_EDGE,    5'd3,  4'd3,  CHK_ONE,   '{4'd0,  1'b1, ST_OK}},
    '{ROW_ITEM, OP_EDGE,    5'd3,  4'd3,  CHK_ONE,   '{4'd0,  1'b1, ST_OK}},
    '{ROW_ITEM, OP_EDGE,    5'd3,  4'd3,  CHK_ONE,   '{4'd0,  1'b1, ST_OK}},
    '{ROW_ITEM, OP_EDGE,    5'd3,  4'd9,  CHK_ONE,   '{4'd0,  1'b1, ST_OK}},
    '{ROW_ITEM, OP_EDGE,    5'd3,  4'd3,  CHK_ONE,   '{4'd0,  1'b1, ST_FULL}},
    '{ROW_ITEM, OP_EDGE,    5'd3,  4'd10, CHK_ONE,   '{4'd0,  1'b1, ST_OK}},
    '{ROW_ITEM, OP_EDGE,    5'd10, 4'd3,  CHK_ONE,   '{4'd0,  1'b1, ST_FULL}},
    '{ROW_ITEM, OP_EDGE,    5'd9,  4'd15, CHK_ONE,   '{4'd0,  1'b1, ST_OK}},
    '{ROW_ITEM, OP_BFS,     5'd3,  4'd0,  CHK_MODEL, NO_VISIT},
    '{ROW_ITEM, OP_DFS,     5'd3,  4'd7,  CHK_MODEL, NO_VISIT},
    '{ROW_CFG,  OP_EDGE,    5'd4,  4'd0,  CHK_NONE,  NO_VISIT},
    '{ROW_ITEM, OP_EDGE,    5'd5,  4'd1,  CHK_ONE,   '{4'd0,  1'b1, ST_RANGE}},
    '{ROW_ITEM, OP_EDGE,    5'd1,  4'd4,  CHK_ONE,   '{4'd0,  1'b1, ST_RANGE}},
    '{ROW_ITEM, OP_BFS,     5'd4,  4'd0,  CHK_ONE,   '{4'd0,  1'b1, ST_RANGE}},
    '{ROW_ITEM, OP_DFS,     5'd3,  4'd0,  CHK_MODEL, NO_VISIT},
    '{ROW_ITEM, OP_EDGE,    5'd0,  4'd3,  CHK_ONE,   '{4'd0,  1'b1, ST_FULL}},
    '{ROW_CFG,  OP_EDGE,    5'd0,  4'd0,  CHK_NONE,  NO_VISIT},
    '{ROW_ITEM, OP_DFS,     5'd0,  4'd0,  CHK_ONE,   '{4'd0,  1'b1, ST_OK}},
    '{ROW_ITEM, OP_EDGE,    5'd0,  4'd0,  CHK_ONE,   '{4'd0,  1'b1, ST_OK}},
    '{ROW_ITEM, OP_EDGE,    5'd0,  4'd1,  CHK_ONE,   '{4'd0,  1'b1, ST_RANGE}},
    '{ROW_ITEM, OP_BFS,     5'd0,  4'd0,  CHK_MODEL, NO_VISIT},
    '{ROW_CFG,  OP_EDGE,    5'd31, 4'd0,  CHK_NONE,  NO_VISIT}
  };

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;  // first_vertex, second_vertex
  logic [OP_W-1:0]        in_tuser   = '0;  // opcode
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // visited_vertex
  logic                   out_tlast;
  logic [ST_W-1:0]        out_tuser;        // status
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data   = '0;

  logic [VTX_W-1:0] adj_list [NUM_VTX][NUM_DEG];
  int unsigned      vertex_degree [NUM_VTX];
  logic [CFG_W-1:0] vertex_cfg = VERTEX_COUNT_RST;
  visit_t           response_q [$];
  visit_t           pending_visits [$];
  int               error_count  = 0;
  int               stall_cycles = 0;
  bit               no_idle      = 1'b0;

  graph_bfs_dfs_traversal dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned active_vertices();
    if (vertex_cfg == 0) return 1;
    if (vertex_cfg > NUM_VTX) return NUM_VTX;
    return 32'(vertex_cfg);
  endfunction

  function automatic void add_response(input visit_t v);
    response_q = {response_q, v};
  endfunction

  function automatic void add_expected(input visit_t v);
    pending_visits = {pending_visits, v};
  endfunction

  function automatic logic [ST_W-1:0] insert_edge(input logic [VTX_W-1:0] u,
                                                 input logic [VTX_W-1:0] v);
    int unsigned n;
    n = active_vertices();
    if (u >= n || v >= n) return ST_RANGE;
    if (u == v) begin
      if (vertex_degree[u] + 2 > NUM_DEG) return ST_FULL;
    end else if (vertex_degree[u] >= NUM_DEG || vertex_degree[v] >= NUM_DEG) begin
      return ST_FULL;
    end
    adj_list[u][vertex_degree[u]] = v;
    vertex_degree[u]++;
    adj_list[v][vertex_degree[v]] = u;
    vertex_degree[v]++;
    return ST_OK;
  endfunction

  function automatic void walk_graph(input logic [VTX_W-1:0] start, input bit depth_first);
    bit               seen [NUM_VTX];
    logic [VTX_W-1:0] work [WORK_SLOTS];
    int unsigned      head;
    int unsigned      tail;
    int unsigned      n;
    int               count;
    logic [VTX_W-1:0] node;
    logic [VTX_W-1:0] nb;
    n     = active_vertices();
    head  = 0;
    tail  = 0;
    count = 0;
    foreach (seen[i]) seen[i] = 1'b0;
    if (!depth_first) seen[start] = 1'b1;
    work[tail] = start;
    tail++;
    while (tail > head) begin
      if (depth_first) begin
        tail--;
        node = work[tail];
        if (seen[node]) continue;
        seen[node] = 1'b1;
      end else begin
        node = work[head];
        head++;
      end
      if (count < NUM_VTX) begin
        add_response(visit_t'{node, 1'b0, ST_OK});
        count++;
      end
      for (int i = 0; i < vertex_degree[node] && i < NUM_DEG; i++) begin
        nb = adj_list[node][i];
        if (nb >= n || seen[nb]) continue;
        if (tail >= WORK_SLOTS) continue;
        if (!depth_first) seen[nb] = 1'b1;
        work[tail] = nb;
        tail++;
      end
    end
    if (count > 0) response_q[count-1].last = 1'b1;
  endfunction

  function automatic void graph_response(input logic [OP_W-1:0] op,
                                         input logic [VTX_W-1:0] a,
                                         input logic [VTX_W-1:0] b);
    response_q.delete();
    if (op == OP_EDGE) begin
      add_response(visit_t'{4'd0, 1'b1, insert_edge(a, b)});
    end else if (op == OP_BFS || op == OP_DFS) begin
      if (a >= active_vertices()) add_response(visit_t'{4'd0, 1'b1, ST_RANGE});
      else walk_graph(a, op == OP_DFS);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic send_item(input logic [OP_W-1:0] op, input logic [VTX_W-1:0] a,
                           input logic [VTX_W-1:0] b, input check_mode_t mode,
                           input visit_t typed);
    @(negedge clk);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {b, a};
    do @(posedge clk); while (!in_tready);
    graph_response(op, a, b);
    case (mode)
      CHK_MODEL: foreach (response_q[i]) add_expected(response_q[i]);
      CHK_ONE:   add_expected(typed);
      default: ;
    endcase
  endtask

  task automatic write_vertex_count(input logic [CFG_W-1:0] value);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_visits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    vertex_cfg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    out_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    visit_t exp_visit;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_visits.size() == 0) begin
        report_mismatch($sformatf("unexpected beat vertex %0d last %0b status %0d",
                                  out_tdata[VTX_W-1:0], out_tlast, out_tuser));
      end else begin
        exp_visit = pending_visits.pop_front();
        if (out_tdata[VTX_W-1:0] !== exp_visit.vertex)
          report_mismatch($sformatf("visited vertex %0d, expected %0d",
                                    out_tdata[VTX_W-1:0], exp_visit.vertex));
        if (out_tlast !== exp_visit.last)
          report_mismatch($sformatf("tlast %0b, expected %0b", out_tlast, exp_visit.last));
        if (out_tuser !== exp_visit.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_tuser, exp_visit.status));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [CFG_W-1:0] phase_cfg [6];
    int unsigned      n;
    int               accepted;
    logic [OP_W-1:0]  op;
    logic [VTX_W-1:0] a;
    logic [VTX_W-1:0] b;
    int unsigned      pick;

    foreach (vertex_degree[i]) vertex_degree[i] = 0;
    phase_cfg[0] = 5'd2;
    phase_cfg[1] = 5'd31;
    phase_cfg[2] = CFG_W'($urandom_range(3, 15));
    phase_cfg[3] = 5'd1;
    phase_cfg[4] = 5'd16;
    phase_cfg[5] = CFG_W'($urandom_range(17, 30));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_CFG)
        write_vertex_count(DIRECTED[i].arg_a);
      else
        send_item(DIRECTED[i].op, DIRECTED[i].arg_a[VTX_W-1:0], DIRECTED[i].arg_b,
                  DIRECTED[i].mode, DIRECTED[i].typed);
    end

    foreach (phase_cfg[p]) begin
      write_vertex_count(phase_cfg[p]);
      no_idle  = (p == 4);
      n        = active_vertices();
      accepted = 0;
      while (accepted < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 55)      op = OP_EDGE;
        else if (pick < 75) op = OP_BFS;
        else if (pick < 95) op = OP_DFS;
        else                op = OP_IGNORED;
        a = ($urandom_range(0, 9) == 0) ? VTX_W'($urandom_range(0, 15))
                                        : VTX_W'($urandom_range(0, n - 1));
        b = ($urandom_range(0, 9) == 0) ? VTX_W'($urandom_range(0, 15))
                                        : VTX_W'($urandom_range(0, n - 1));
        if ($urandom_range(0, 9) == 0) b = a;
        send_item(op, a, b, CHK_MODEL, NO_VISIT);
        if (op != OP_IGNORED) accepted++;
      end
    end
    no_idle = 1'b0;

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_visits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/gbt_pkg.sv
hdl/gbt_ram.sv
hdl/graph_bfs_dfs_traversal.sv
sim/graph_bfs_dfs_traversal_tb.sv
